[src/sha_pkg.sv]
package sha_pkg;

    // Round constants
    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Classified word passed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_OUT
    } t_state;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[src/sha_front.sv]
// Input queue: two-entry FIFO that decouples the stream from the engine
module sha_front import sha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_cmd       i_cmd,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cmd       o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp)) else $error("pointers disagree");
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (r_wp == r_rp)) else $error("full pointers disagree");
endmodule

[src/sha_core.sv]
// Block buffer, padding sequencer, round engine and digest output register
module sha_core import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_word,
    output logic [2:0]  o_index,
    output logic        o_last
);
    t_state      r_state, n_state;
    logic [31:0] r_blk [16];  // block buffer, big-endian words
    logic [31:0] n_blk [16];
    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [5:0]  r_rnd;
    logic [3:0]  r_ld;
    logic        r_fin;     // message end pending
    logic        r_pad2;    // length still to be placed in a second block
    logic        r_lead;    // second block opens with the pad byte
    logic [2:0]  r_oi;
    logic        r_ov;

    logic        w_take;
    logic [5:0]  w_fill1;
    logic [5:0]  w_pos;
    logic [63:0] w_len;
    logic        w_full;
    logic [31:0] w_s0, w_s1, w_wn, w_t1, w_t2, w_wt;

    assign o_ready = (r_state == S_IDLE);
    assign w_take  = i_valid && o_ready;
    assign w_fill1 = r_fill + 6'd1;
    assign w_full  = i_cmd.present && (r_fill == 6'd63);
    // pad byte position and bit length after this word
    assign w_pos   = i_cmd.present ? w_fill1 : r_fill;
    assign w_len   = r_bits + (i_cmd.present ? 64'd8 : 64'd0);

    // Message schedule on a 16-word window
    assign w_s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wn = w_s1 + r_w[9] + w_s0 + r_w[0];
    assign w_wt = r_w[0];

    // One round
    assign w_t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
                + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + K_TAB[r_rnd] + w_wt;
    assign w_t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
                + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid && (w_full || i_cmd.last)) n_state = S_LOAD;
            S_LOAD:  if (r_ld == 4'd15) n_state = S_ROUND;
            S_ROUND: if (r_rnd == 6'd63) n_state = S_ADD;
            S_ADD:   n_state = r_fin ? (r_pad2 ? S_PAD : S_OUT) : S_IDLE;
            S_PAD:   n_state = S_LOAD;
            S_OUT:   if (o_valid && i_ready && r_oi == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_valid = r_ov;
        o_word  = r_h[r_oi];
        o_index = r_oi;
        o_last  = (r_oi == 3'd7);
    end

    // Next block contents: incoming byte, in-place padding, or the extra pad block
    always_comb begin
        n_blk = r_blk;
        if (w_take) begin
            for (int k = 0; k < 16; k++) begin
                for (int l = 0; l < 4; l++) begin
                    if (i_cmd.present && 6'(4 * k + l) == r_fill) begin
                        n_blk[k][31 - 8 * l -: 8] = i_cmd.data;
                    end
                    if (i_cmd.last && !w_full) begin
                        if (6'(4 * k + l) == w_pos) begin
                            n_blk[k][31 - 8 * l -: 8] = PAD_BYTE;
                        end else if (6'(4 * k + l) > w_pos) begin
                            n_blk[k][31 - 8 * l -: 8] = 8'h00;
                        end
                    end
                end
            end
            // length fits behind the pad byte
            if (i_cmd.last && !w_full && w_pos < 6'd56) begin
                n_blk[14] = w_len[63:32];
                n_blk[15] = w_len[31:0];
            end
        end else if (r_state == S_PAD) begin
            for (int k = 0; k < 14; k++) n_blk[k] = 32'h0;
            if (r_lead) n_blk[0] = {PAD_BYTE, 24'h0};
            n_blk[14] = r_bits[63:32];
            n_blk[15] = r_bits[31:0];
        end
    end

    // Block buffer
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
    end

    // Control and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= 6'd0;
            r_bits  <= 64'd0;
            r_ld    <= 4'd0;
            r_rnd   <= 6'd0;
            r_fin   <= 1'b0;
            r_pad2  <= 1'b0;
            r_lead  <= 1'b0;
            r_oi    <= 3'd0;
            r_ov    <= 1'b0;
            for (int j = 0; j < 8; j++) r_h[j] <= H_INIT[j];
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (i_cmd.present) begin
                            r_fill <= w_fill1;
                            r_bits <= r_bits + 64'd8;
                        end
                        r_fin <= i_cmd.last;
                        // full block with end: 0x80 opens a fresh block
                        // padded byte landed past 55: length needs a second block
                        r_pad2 <= i_cmd.last && (w_full || w_pos >= 6'd56);
                        r_lead <= i_cmd.last && w_full;
                        r_oi <= 3'd0;
                        r_ld <= 4'd0;
                        for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
                    end
                end
                S_LOAD: begin
                    r_w[r_ld] <= r_blk[r_ld];
                    r_ld <= r_ld + 4'd1;
                    r_rnd <= 6'd0;
                end
                S_ROUND: begin
                    for (int j = 0; j < 15; j++) r_w[j] <= r_w[j + 1];
                    r_w[15] <= w_wn;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    r_rnd <= r_rnd + 6'd1;
                end
                S_ADD: begin
                    for (int j = 0; j < 8; j++) r_h[j] <= r_h[j] + r_v[j];
                    r_fill <= 6'd0;
                    if (r_fin && !r_pad2) begin
                        r_ov <= 1'b1;
                        r_oi <= 3'd0;
                    end
                end
                S_PAD: begin
                    r_pad2 <= 1'b0;
                    r_oi   <= 3'd0;
                    r_ld   <= 4'd0;
                    for (int j = 0; j < 8; j++) r_v[j] <= r_h[j];
                end
                S_OUT: begin
                    if (o_valid && i_ready) begin
                        r_oi <= r_oi + 3'd1;
                        if (r_oi == 3'd7) begin
                            r_ov   <= 1'b0;
                            r_fin  <= 1'b0;
                            r_bits <= 64'd0;
                            for (int j = 0; j < 8; j++) r_h[j] <= H_INIT[j];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_state == S_OUT)) else $error("output outside OUT");
    a_rnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_rnd == 6'd63) |=> (r_state == S_ADD))
        else $error("round count slip");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |=> (r_fill == 6'd0)) else $error("fill not cleared");
endmodule

[src/sha256_byte_stream_hasher.sv]
// Channel  Dir  tdata                         tuser
// s_axis   in   [7:0] msg_byte                [0] byte_present, tlast = msg_end
// m_axis   out  [31:0] digest_word            [2:0] word_index, tlast = digest_last
//
// A byte that does not fill a block passes through the queue into the block buffer.
// A full block is loaded, run through the rounds and added on the single round unit;
// message end adds one or two such compressions (a second one after the pad
// state), then eight output words.
// i_rst_n is synchronous, active low; it restores the initial hash values.
// Either side may stall; a two-word queue sits ahead of the engine.
module sha256_byte_stream_hasher import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast
);
    t_cmd w_in, w_q;
    logic w_qv, w_qr;

    assign w_in = '{data: s_axis_tdata, present: s_axis_tuser, last: s_axis_tlast};

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_q)
    );

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_q),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_word(m_axis_tdata), .o_index(m_axis_tuser), .o_last(m_axis_tlast)
    );
endmodule

[verif/tb_sha256_byte_stream_hasher.sv]
`timescale 1ns / 100ps

module tb_sha256_byte_stream_hasher;
    import sha_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] msg_byte
    logic        s_axis_tuser;   // [0] byte_present
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] digest_word
    logic [2:0]  m_axis_tuser;   // [2:0] word_index
    logic        m_axis_tlast;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // Hash state mirrored in the testbench
    logic [7:0]  blk_bytes [64];
    int unsigned blk_count;
    logic [31:0] hash_state [8];
    logic [63:0] bit_length;

    t_digest_word digest_queue [$];

    int src_idle_pct;
    int snk_idle_pct;
    int err_count;
    int word_count;
    int msg_count;
    int byte_count;

    sha256_byte_stream_hasher dut (.*);

    // Clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One compression of the buffered block into hash_state
    task automatic compress_blk();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            sched[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (int t = 16; t < 64; t++)
            sched[t] = (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10))
                     + sched[t-7] + sched[t-16]
                     + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3));
        a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
        e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[t] + sched[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
        hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
    endtask

    task automatic hash_init();
        blk_count = 0;
        bit_length = '0;
        for (int i = 0; i < 8; i++)
            hash_state[i] = H_INIT[i];
    endtask

    // Absorb one word; on message end pad, finish and queue the digest
    task automatic hash_absorb(input logic [7:0] data, input logic present, input logic fin);
        int unsigned pos;
        t_digest_word dw;
        if (present) begin
            blk_bytes[blk_count] = data;
            blk_count++;
            bit_length += 64'd8;
            if (blk_count == 64) begin
                compress_blk();
                blk_count = 0;
            end
        end
        if (fin) begin
            pos = blk_count;
            blk_bytes[pos] = PAD_BYTE;
            pos++;
            if (pos > 56) begin
                while (pos < 64) begin
                    blk_bytes[pos] = 8'h00;
                    pos++;
                end
                compress_blk();
                pos = 0;
            end
            while (pos < 56) begin
                blk_bytes[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                blk_bytes[56+i] = bit_length[63-8*i -: 8];
            compress_blk();
            for (int i = 0; i < 8; i++) begin
                dw.word = hash_state[i];
                dw.index = 3'(i);
                dw.last = (i == 7);
                digest_queue.push_back(dw);
            end
            msg_count++;
            hash_init();
        end
    endtask

    // Send one word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] data, input logic present, input logic fin);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= present;
        s_axis_tlast  <= fin;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        hash_absorb(data, present, fin);
        if (present) byte_count++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len - 1; i++)
            send_word(8'($urandom), 1'b1, 1'b0);
        if (len == 0) send_word(8'($urandom), 1'b0, 1'b1);
        else if ($urandom_range(1)) send_word(8'($urandom), 1'b1, 1'b1);
        else begin
            send_word(8'($urandom), 1'b1, 1'b0);
            send_word(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic drain_digests();
        s_axis_tvalid <= 1'b0;
        while (digest_queue.size() != 0) @(posedge i_clk);
    endtask

    // Directed: empty message, "abc", extreme bytes, ignored no-byte words
    task automatic test_directed();
        send_word(8'hff, 1'b0, 1'b1);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(8'haa, 1'b1, 1'b1);
        drain_digests();
    endtask

    // Padding edges: lengths around 55/56/64 bytes
    task automatic test_pad_edges();
        send_message(55);
        send_message(56);
        drain_digests();
        send_message(64);
    endtask

    // Random messages, mostly short, occasional no-byte noise words
    task automatic test_random_msgs(input int n_bytes);
        int target;
        target = byte_count + n_bytes;
        while (byte_count < target) begin
            if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
            else send_message($urandom_range(3) == 0 ? $urandom_range(57, 70)
                                                     : $urandom_range(0, 12));
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            word_count++;
            if (digest_queue.size() == 0) begin
                $display("%0t: unexpected digest word act=%h/%0d/%b", $time,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end else begin
                exp_w = digest_queue.pop_front();
                if (m_axis_tdata !== exp_w.word || m_axis_tuser !== exp_w.index
                    || m_axis_tlast !== exp_w.last) begin
                    $display("%0t: digest mismatch exp=%h/%0d/%b act=%h/%0d/%b", $time,
                             exp_w.word, exp_w.index, exp_w.last,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Sink backpressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        err_count = 0; word_count = 0; msg_count = 0; byte_count = 0;
        src_idle_pct = 7; snk_idle_pct = 48;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0; s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        hash_init();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pad_edges();
        test_random_msgs(50);
        drain_digests();
        src_idle_pct = 48; snk_idle_pct = 7;
        test_random_msgs(50);
        src_idle_pct = 0; snk_idle_pct = 0;
        test_random_msgs(50);

        drain_digests();
        repeat (400) @(posedge i_clk);
        $display("Hashed %0d messages, %0d bytes, checked %0d digest words", msg_count,
                 byte_count, word_count);
        $display("Covered empty, padding-boundary and multi-block messages under stalls");
        if (err_count == 0 && digest_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
